@@ hw/rtl/mna_pkg.sv @@
// Shared types and constants for the mixed number arithmetic unit.
// No dependencies; every other file imports this package.
package mna_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  localparam int QW = 28;  // magnitude of the improper result numerator
  localparam int DW = 21;  // result denominator

  typedef struct packed {
    logic          arith;  // add/sub/mul/div with a nonzero denominator
    logic          err;
    logic [1:0]    cmp;
    logic          neg;
    logic [DW-1:0] den;
  } ctl_t;

endpackage

@@ hw/rtl/mna_front.sv @@
// Front end: improper fractions, cross products, numerator select.
// Three register stages; depends on mna_pkg.
module mna_front import mna_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [47:0]   in_data,
  output logic          f_vld,
  output logic [QW-1:0] f_mag,
  output ctl_t          f_ctl
);

  // stage 1
  logic        v1_r;
  logic [2:0]  op1_r;
  logic [13:0] n1_r, n2_r;
  logic [6:0]  ad1_r, bd1_r;
  // stage 2
  logic        v2_r;
  logic [2:0]  op2_r;
  logic [20:0] p1_r, p2_r, dd_r, dv_r;
  logic [27:0] pm_r;
  // stage 3
  logic        v3_r;
  logic [QW-1:0] mag_r;
  ctl_t        ctl_r;

  logic [6:0] aw, an, ad, bw, bn, bd;
  assign aw = in_data[9:3];
  assign an = in_data[16:10];
  assign ad = in_data[23:17];
  assign bw = in_data[30:24];
  assign bn = in_data[37:31];
  assign bd = in_data[44:38];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  logic signed [29:0] num;
  logic [DW-1:0]      den;
  logic               arith;
  ctl_t               ctl_nxt;

  always_comb begin
    arith = 1'b1;
    num   = '0;
    den   = dd_r;
    case (op2_r)
      OP_ADD: num = $signed({9'd0, p1_r}) + $signed({9'd0, p2_r});
      OP_SUB: num = $signed({9'd0, p1_r}) - $signed({9'd0, p2_r});
      OP_MUL: num = $signed({2'd0, pm_r});
      OP_DIV: begin
        num = $signed({9'd0, p1_r});
        den = dv_r;
      end
      default: arith = 1'b0;
    endcase
    ctl_nxt       = '0;
    ctl_nxt.err   = arith && (den == '0);
    ctl_nxt.arith = arith && (den != '0);
    ctl_nxt.neg   = num[29];
    ctl_nxt.den   = den;
    if (op2_r == OP_CMP) begin
      ctl_nxt.cmp = (p1_r > p2_r) ? CMP_GT : ((p1_r < p2_r) ? CMP_LT : CMP_EQ);
    end
  end

  logic [29:0] num_abs;
  assign num_abs = num[29] ? 30'(-num) : 30'(num);

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= in_data[2:0];
      n1_r  <= {7'd0, aw} * {7'd0, ad} + {7'd0, an};
      n2_r  <= {7'd0, bw} * {7'd0, bd} + {7'd0, bn};
      ad1_r <= ad;
      bd1_r <= bd;
      op2_r <= op1_r;
      // left/right of compare equal these two cross products
      p1_r  <= {7'd0, n1_r} * {14'd0, bd1_r};
      p2_r  <= {7'd0, n2_r} * {14'd0, ad1_r};
      pm_r  <= {14'd0, n1_r} * {14'd0, n2_r};
      dd_r  <= {14'd0, ad1_r} * {14'd0, bd1_r};
      dv_r  <= {14'd0, ad1_r} * {7'd0, n2_r};
      mag_r <= num_abs[QW-1:0];
      ctl_r <= ctl_nxt;
    end
  end

  assign f_vld = v3_r;
  assign f_mag = mag_r;
  assign f_ctl = ctl_r;

endmodule

@@ hw/rtl/mna_div.sv @@
// Unsigned restoring divider, one quotient bit per register stage.
// Depends on mna_pkg for widths and the side-band struct.
module mna_div import mna_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          d_vld,
  input  logic [QW-1:0] d_mag,
  input  ctl_t          d_ctl,
  output logic          q_vld,
  output logic [QW-1:0] q_quo,
  output logic [DW-1:0] q_rem,
  output ctl_t          q_ctl
);

  logic          vld_r [0:QW];
  logic [QW-1:0] sh_r  [0:QW];
  logic [DW-1:0] rem_r [0:QW];
  ctl_t          ctl_r [0:QW];

  assign vld_r[0] = d_vld;
  assign sh_r[0]  = d_mag;
  assign rem_r[0] = '0;
  assign ctl_r[0] = d_ctl;

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic [DW:0] trial;
      logic        take;
      assign trial = {rem_r[k], sh_r[k][QW-1]};
      assign take  = trial >= {1'b0, ctl_r[k].den};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k+1] <= 1'b0;
        end else if (adv) begin
          vld_r[k+1] <= vld_r[k];
        end
      end

      // shift dividend out of the top, quotient bits in at the bottom
      always_ff @(posedge clk) begin
        if (adv) begin
          sh_r[k+1]  <= {sh_r[k][QW-2:0], take};
          rem_r[k+1] <= take ? DW'(trial - {1'b0, ctl_r[k].den}) : trial[DW-1:0];
          ctl_r[k+1] <= ctl_r[k];
        end
      end
    end
  endgenerate

  assign q_vld = vld_r[QW];
  assign q_quo = sh_r[QW];
  assign q_rem = rem_r[QW];
  assign q_ctl = ctl_r[QW];

endmodule

@@ hw/rtl/mixed_number_arithmetic_unit.sv @@
// Channel | dir | fields (low bit up)
// in_     | in  | op[2:0] a_whole a_num a_den b_whole b_num b_den, 48-bit tdata
// out_    | out | res_whole res_num res_den cmp_out zero_den_err, 80-bit tdata
//
// One request per cycle while the output is not stalled; the pipeline is 3 front stages,
// 28 divider stages and an output register. The divider's one-bit-per-stage chain sets depth.
// rst_n clears all valid bits. A stalled output freezes the whole pipeline.
// Top level; depends on mna_pkg, mna_front and mna_div.
module mixed_number_arithmetic_unit import mna_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op, a_whole, a_num, a_den, b_whole, b_num, b_den
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // res_whole, res_num, res_den, cmp_out, zero_den_err
);

  logic          adv;
  logic          f_vld, q_vld;
  logic [QW-1:0] f_mag, q_quo;
  logic [DW-1:0] q_rem;
  ctl_t          f_ctl, q_ctl;

  logic          out_vld_r;
  logic [79:0]   out_data_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  mna_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(in_tvalid), .in_data(in_tdata),
    .f_vld(f_vld), .f_mag(f_mag), .f_ctl(f_ctl)
  );

  mna_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .d_vld(f_vld), .d_mag(f_mag), .d_ctl(f_ctl),
    .q_vld(q_vld), .q_quo(q_quo), .q_rem(q_rem), .q_ctl(q_ctl)
  );

  logic [28:0] whole;
  logic [21:0] rnum;
  logic [20:0] rden;
  logic [79:0] out_data_nxt;

  // quotient and remainder take the numerator's sign
  always_comb begin
    whole = '0;
    rnum  = '0;
    rden  = '0;
    if (q_ctl.arith) begin
      whole = q_ctl.neg ? 29'(-{1'b0, q_quo}) : {1'b0, q_quo};
      rnum  = q_ctl.neg ? 22'(-{1'b0, q_rem}) : {1'b0, q_rem};
      rden  = q_ctl.den;
    end
    out_data_nxt = {5'd0, q_ctl.err, q_ctl.cmp, rden, rnum, whole};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[74] |-> out_tdata[73:0] == '0)
    else $error("error flag with nonzero fields");

  a_cmp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[73:72] != 2'd3)
    else $error("bad compare code");

  a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[73:72] != 2'd0 |-> out_tdata[71:51] == '0)
    else $error("compare result with a denominator");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

@@ sim/mixed_number_arithmetic_unit_chk.sv @@
// Checker for the mixed number arithmetic unit: watches both stream channels,
// predicts each result from the accepted request and compares field by field.
// Depends on mna_pkg for op and compare codes.
`timescale 1ns / 100ps
module mixed_number_arithmetic_unit_chk import mna_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  output int          fail_cnt,
  output int          pending
);

  typedef struct packed {
    logic              zero_den_err;
    logic [1:0]        cmp_out;
    logic [20:0]       res_den;
    logic signed [21:0] res_num;
    logic signed [28:0] res_whole;
  } mixed_res_t;

  mixed_res_t expected_q[$];

  function automatic mixed_res_t mixed_predict(logic [47:0] d);
    mixed_res_t r;
    logic [2:0] op;
    longint aw, an, ad, bw, bn, bd, n1, n2, nm, dn, q, rm, lhs, rhs;
    r = '0;
    op = d[2:0];
    aw = d[9:3];   an = d[16:10]; ad = d[23:17];
    bw = d[30:24]; bn = d[37:31]; bd = d[44:38];
    n1 = aw * ad + an;
    n2 = bw * bd + bn;
    case (op)
      OP_ADD: begin nm = n1 * bd + n2 * ad; dn = ad * bd; end
      OP_SUB: begin nm = n1 * bd - n2 * ad; dn = ad * bd; end
      OP_MUL: begin nm = n1 * n2; dn = ad * bd; end
      OP_DIV: begin nm = n1 * bd; dn = ad * n2; end
      OP_CMP: begin
        lhs = aw * bd * ad + an * bd;
        rhs = bw * ad * bd + bn * ad;
        r.cmp_out = (lhs > rhs) ? CMP_GT : ((lhs < rhs) ? CMP_LT : CMP_EQ);
        return r;
      end
      default: return r;
    endcase
    if (dn == 0) begin
      r.zero_den_err = 1'b1;
      return r;
    end
    q = nm / dn;
    rm = nm - q * dn;
    r.res_whole = q[28:0];
    r.res_num = rm[21:0];
    r.res_den = dn[20:0];
    return r;
  endfunction

  initial pending = 0;

  always @(posedge clk) begin
    mixed_res_t e, a;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_cnt <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_q.push_back(mixed_predict(in_tdata));
      if (out_tvalid && out_tready) begin
        a = out_tdata[74:0];
        if (out_tdata[79:75] != 0) begin
          $error("pad bits expected 0 actual %h", out_tdata[79:75]);
          errs++;
        end
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (a.res_whole !== e.res_whole)
            $error("res_whole expected %0d actual %0d", e.res_whole, a.res_whole);
          if (a.res_num !== e.res_num)
            $error("res_num expected %0d actual %0d", e.res_num, a.res_num);
          if (a.res_den !== e.res_den)
            $error("res_den expected %0d actual %0d", e.res_den, a.res_den);
          if (a.cmp_out !== e.cmp_out)
            $error("cmp_out expected %0d actual %0d", e.cmp_out, a.cmp_out);
          if (a.zero_den_err !== e.zero_den_err)
            $error("zero_den_err expected %0d actual %0d", e.zero_den_err,
                   a.zero_den_err);
          if (a !== e) errs++;
        end
      end
      fail_cnt <= fail_cnt + errs;
    end
    pending <= expected_q.size();
  end

endmodule

@@ sim/mixed_number_arithmetic_unit_tb.sv @@
// Testbench top for the mixed number arithmetic unit: drives directed and
// random requests with idle/stall phases; checking lives in the _chk module.
// Depends on mna_pkg, the RTL and mixed_number_arithmetic_unit_chk.
`timescale 1ns / 100ps
module mixed_number_arithmetic_unit_tb import mna_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  int          fail_cnt;
  int          pending;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mixed_number_arithmetic_unit u_top (.*);

  mixed_number_arithmetic_unit_chk u_chk (.*);

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= stall_pct);

  function automatic logic [47:0] pack_req(logic [2:0] op, logic [6:0] aw, an, ad,
                                           logic [6:0] bw, bn, bd);
    return {3'b000, bd, bn, bw, ad, an, aw, op};
  endfunction

  // Hold valid until accepted; valid stays high across back-to-back requests.
  task automatic send_req(logic [47:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [6:0] rnd_field;
    case ($urandom_range(5))
      0: return 7'd0;
      1: return 7'd127;
      2: return 7'($urandom_range(1, 9));
      default: return 7'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rnd_req;
    logic [2:0] op;
    op = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    return pack_req(op, rnd_field(), rnd_field(), rnd_field(),
                    rnd_field(), rnd_field(), rnd_field());
  endfunction

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [2:0] op;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, each op, zero denominators, equal compare, unused codes
    for (int k = 0; k < 8; k++) begin
      op = 3'(k);
      send_req(pack_req(op, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127));
      send_req(pack_req(op, 7'd0, 7'd5, 7'd0, 7'd3, 7'd1, 7'd2));
    end
    send_req(pack_req(OP_SUB, 7'd0, 7'd1, 7'd127, 7'd127, 7'd127, 7'd1));
    send_req(pack_req(OP_DIV, 7'd5, 7'd1, 7'd2, 7'd0, 7'd0, 7'd9));
    send_req(pack_req(OP_CMP, 7'd1, 7'd1, 7'd2, 7'd1, 7'd2, 7'd4));
    send_req(pack_req(OP_CMP, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0));
    send_req(pack_req(OP_MUL, 7'd0, 7'd0, 7'd1, 7'd0, 7'd0, 7'd1));
    send_req(pack_req(OP_SUB, 7'd1, 7'd0, 7'd3, 7'd2, 7'd0, 7'd3));
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 25 : 65) : 0;
      stall_pct = (ph == 2) ? 65 : ((ph == 3) ? 25 : 0);
      for (int i = 0; i < 360; i++) send_req(rnd_req());
      drain();
    end
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
